// ----- hdl/mtwg_pkg.sv -----
// Package for the MT19937 word generator: constants, item codes and the tempering function.
// Used by mt19937_word_generator. No dependencies.
package mtwg_pkg;

  localparam int unsigned WordCount = 624;
  localparam int unsigned ShiftDist = 397;

  localparam logic [9:0]  LAST_INDEX   = 10'd623;
  localparam logic [9:0]  POS_TWIST    = 10'd624;
  localparam logic [9:0]  POS_UNSEEDED = 10'd625;
  localparam logic [9:0]  FAR_OFFSET   = 10'd397;
  localparam logic [9:0]  FAR_WRAP     = 10'd227;

  localparam logic [31:0] TWIST_CONST  = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] HALF_MASK    = 32'hffff_0000;
  localparam logic [31:0] LCG_MUL      = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  localparam logic [1:0]  KIND_DRAW    = 2'd0;
  localparam logic [1:0]  KIND_RESEED  = 2'd1;
  localparam logic [1:0]  KIND_LOAD    = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SEED_HI = 8'b0000_0010,
    ST_SEED_LO = 8'b0000_0100,
    ST_TW_PRE  = 8'b0000_1000,
    ST_TW_RD   = 8'b0001_0000,
    ST_TW_WR   = 8'b0010_0000,
    ST_DRAW_RD = 8'b0100_0000,
    ST_DRAW_WR = 8'b1000_0000
  } state_e;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- hdl/mt19937_word_generator.sv -----
// MT19937 word generator: 624-word state memory with a sequencer for seeding,
// twisting and tempered draws. Depends on mtwg_pkg.
// Draw: read (ST_DRAW_RD), temper and register once the output is free (ST_DRAW_WR), then
//   idle for the next item; a twist runs first when due, seeding first after reset. Reseed:
// seeding only. Load: written on acceptance. Hold a draw while the previous result waits.
// Reset clears control, the seed register (4357) and the position, not the state memory.
module mt19937_word_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  state_index_i,
  input  logic [31:0] state_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o
);

  logic [31:0] mem_q [mtwg_pkg::WordCount];
  logic [31:0] rd_a_q, rd_b_q;
  logic [9:0]  addr_a, addr_b;
  logic        wr_en;
  logic [9:0]  wr_addr;
  logic [31:0] wr_data;

  mtwg_pkg::state_e state_q, state_d;
  logic [9:0]  pos_q, pos_d;
  logic [9:0]  idx_q, idx_d;
  logic [31:0] seed_q;
  logic [31:0] lcg_q, lcg_d;
  logic [31:0] hi_q, hi_d;
  logic [31:0] cur_q, cur_d;
  logic        draw_pend_q, draw_pend_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q, out_d;

  logic        in_fire, out_free, last_idx;
  logic [31:0] lcg_next, tw_y, tw_v;
  logic [9:0]  nxt_idx, far_idx;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == mtwg_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_q;
  assign in_fire       = in_valid_i & in_ready_o;
  assign out_free      = ~out_valid_q | out_ready_i;
  assign last_idx      = (idx_q == mtwg_pkg::LAST_INDEX);

  assign lcg_next = lcg_q * mtwg_pkg::LCG_MUL + 32'd1;
  assign nxt_idx  = last_idx ? 10'd0 : idx_q + 10'd1;
  assign far_idx  = (idx_q >= mtwg_pkg::FAR_WRAP) ? idx_q - mtwg_pkg::FAR_WRAP
                                                  : idx_q + mtwg_pkg::FAR_OFFSET;
  assign tw_y     = (cur_q & mtwg_pkg::HIGH_BIT) | (rd_a_q & mtwg_pkg::LOW_BITS);
  assign tw_v     = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtwg_pkg::TWIST_CONST : 32'd0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    lcg_d       = lcg_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    draw_pend_d = draw_pend_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    addr_a      = 10'd0;
    addr_b      = 10'd0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = tw_v;
    case (state_q)
      mtwg_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (kind_i)
            mtwg_pkg::KIND_DRAW: begin
              if (pos_q == mtwg_pkg::POS_UNSEEDED) begin
                lcg_d       = mtwg_pkg::DEFAULT_SEED;
                idx_d       = 10'd0;
                draw_pend_d = 1'b1;
                state_d     = mtwg_pkg::ST_SEED_HI;
              end else if (pos_q == mtwg_pkg::POS_TWIST) begin
                state_d = mtwg_pkg::ST_TW_PRE;
              end else begin
                state_d = mtwg_pkg::ST_DRAW_RD;
              end
            end
            mtwg_pkg::KIND_RESEED: begin
              lcg_d       = seed_q;
              idx_d       = 10'd0;
              draw_pend_d = 1'b0;
              state_d     = mtwg_pkg::ST_SEED_HI;
            end
            mtwg_pkg::KIND_LOAD: begin
              wr_en   = (state_index_i <= mtwg_pkg::LAST_INDEX);
              wr_addr = state_index_i;
              wr_data = state_word_i;
              pos_d   = mtwg_pkg::POS_TWIST;
            end
            default: begin
            end
          endcase
        end
      end
      mtwg_pkg::ST_SEED_HI: begin
        hi_d    = lcg_q & mtwg_pkg::HALF_MASK;
        lcg_d   = lcg_next;
        state_d = mtwg_pkg::ST_SEED_LO;
      end
      mtwg_pkg::ST_SEED_LO: begin
        wr_en   = 1'b1;
        wr_data = hi_q | {16'd0, lcg_q[31:16]};
        lcg_d   = lcg_next;
        if (last_idx) begin
          pos_d   = mtwg_pkg::POS_TWIST;
          idx_d   = 10'd0;
          state_d = draw_pend_q ? mtwg_pkg::ST_TW_PRE : mtwg_pkg::ST_IDLE;
        end else begin
          idx_d   = idx_q + 10'd1;
          state_d = mtwg_pkg::ST_SEED_HI;
        end
      end
      mtwg_pkg::ST_TW_PRE: begin
        addr_a  = 10'd0;
        idx_d   = 10'd0;
        state_d = mtwg_pkg::ST_TW_RD;
      end
      mtwg_pkg::ST_TW_RD: begin
        if (idx_q == 10'd0) begin
          cur_d = rd_a_q;
        end
        addr_a  = nxt_idx;
        addr_b  = far_idx;
        state_d = mtwg_pkg::ST_TW_WR;
      end
      mtwg_pkg::ST_TW_WR: begin
        wr_en = 1'b1;
        cur_d = rd_a_q;
        if (last_idx) begin
          pos_d   = 10'd0;
          idx_d   = 10'd0;
          state_d = mtwg_pkg::ST_DRAW_RD;
        end else begin
          idx_d   = idx_q + 10'd1;
          state_d = mtwg_pkg::ST_TW_RD;
        end
      end
      mtwg_pkg::ST_DRAW_RD: begin
        addr_a  = pos_q;
        state_d = mtwg_pkg::ST_DRAW_WR;
      end
      mtwg_pkg::ST_DRAW_WR: begin
        addr_a = pos_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = mtwg_pkg::temper(rd_a_q);
          pos_d       = pos_q + 10'd1;
          state_d     = mtwg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mtwg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtwg_pkg::ST_IDLE;
      pos_q       <= mtwg_pkg::POS_UNSEEDED;
      idx_q       <= 10'd0;
      seed_q      <= mtwg_pkg::DEFAULT_SEED;
      draw_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      draw_pend_q <= draw_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lcg_q <= lcg_d;
    hi_q  <= hi_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtwg_pkg::ST_TW_WR && last_idx)
      |=> (pos_q == 10'd0 && state_q == mtwg_pkg::ST_DRAW_RD))
    else $error("twist did not end in a draw from position zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mtwg_pkg::POS_UNSEEDED)
    else $error("read position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtwg_pkg::ST_DRAW_RD || state_q == mtwg_pkg::ST_DRAW_WR)
      |-> (pos_q < mtwg_pkg::POS_TWIST))
    else $error("draw from a position that needs a twist");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == mtwg_pkg::KIND_DRAW && pos_q < mtwg_pkg::POS_TWIST)
      |=> (state_q == mtwg_pkg::ST_DRAW_RD))
    else $error("ready draw did not go straight to the read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtwg_pkg::ST_DRAW_WR && out_free) |=> out_valid_q)
    else $error("finished draw did not present a result");

endmodule
